[design/double_hash_table_assert.svh]
// Assertion macros used by the double hash table checker.
`ifndef DOUBLE_HASH_TABLE_ASSERT_SVH
`define DOUBLE_HASH_TABLE_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define DHT_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define DHT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/dht_pkg.sv]
// Shared constants, types and helper functions for the double hash table.
`timescale 1ns / 1ps

package dht_pkg;

  localparam int KEY_W          = 32;
  localparam int HASH_STEPS     = 4;
  localparam int HASH_CYCLES    = KEY_W / HASH_STEPS;
  localparam int HCNT_W         = $clog2(HASH_CYCLES);
  localparam int REM_W          = 12;
  localparam int DEF_TABLE_SIZE = 13;
  localparam int DEF_STEP_PRIME = 7;

  localparam logic       OP_INSERT    = 1'b0;
  localparam logic       OP_SEARCH    = 1'b1;
  localparam logic [1:0] ST_INSERTED  = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_FOUND     = 2'd2;
  localparam logic [1:0] ST_NOT_FOUND = 2'd3;

  typedef struct packed {
    logic clr;
    logic load;
    logic hash;
    logic stride;
    logic probe;
    logic out_load;
  } dht_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic hash_last;
    logic stride_last;
    logic probe_done;
    logic out_free;
  } dht_sts_t;

  // One restoring step of a remainder: shift in one bit, then subtract the
  // modulus once. The remainder stays below the modulus.
  function automatic logic [REM_W-1:0] mod_shift(input logic [REM_W-1:0] rem,
                                                 input logic bit_in,
                                                 input logic [REM_W:0] modulus);
    logic [REM_W:0] t;
    t = {rem, bit_in};
    if (t >= modulus) begin
      t = t - modulus;
    end
    return t[REM_W-1:0];
  endfunction

endpackage

[design/dht_datapath.sv]
// Datapath: key remainders, probe address walk, slot memory and result register.
`timescale 1ns / 1ps

module dht_datapath #(
  parameter int TABLE_SIZE = dht_pkg::DEF_TABLE_SIZE,
  parameter int STEP_PRIME = dht_pkg::DEF_STEP_PRIME
) (
  input  logic                    clk,
  input  logic                    rst,
  input  dht_pkg::dht_cmd_t       cmd,
  output dht_pkg::dht_sts_t       sts,
  input  logic                    opcode,
  input  logic [dht_pkg::KEY_W-1:0] key,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [1:0]              status,
  output logic [3:0]              slot_index
);

  localparam int IW  = $clog2(TABLE_SIZE);
  localparam int CW  = $clog2(TABLE_SIZE + 1);
  localparam int SW  = $clog2(STEP_PRIME);
  localparam int SPW = $clog2(STEP_PRIME + 1);
  localparam int SCW = $clog2(SPW);
  localparam int KW  = dht_pkg::KEY_W;
  localparam logic [dht_pkg::REM_W:0] MOD_T = (dht_pkg::REM_W + 1)'(TABLE_SIZE);
  localparam logic [dht_pkg::REM_W:0] MOD_S = (dht_pkg::REM_W + 1)'(STEP_PRIME);

  logic [KW-1:0]             key_q;
  logic                      op_q;
  logic [KW-1:0]             kshift;
  logic [dht_pkg::HCNT_W-1:0] hcnt;
  logic [IW-1:0]             rem_h;
  logic [IW-1:0]             rem_h_next;
  logic [SW-1:0]             rem_s;
  logic [SW-1:0]             rem_s_next;
  logic [SPW-1:0]            step_q;
  logic [SCW-1:0]            scnt;
  logic [IW-1:0]             stride;
  logic [IW-1:0]             rd_idx;
  logic [IW-1:0]             rd_idx_next;
  logic [IW:0]               idx_sum;
  logic [CW-1:0]             issued;
  logic [CW-1:0]             compared;
  logic                      pend;
  logic [IW-1:0]             cmp_idx;
  logic [IW-1:0]             clr_addr;
  logic [KW:0]               mem [TABLE_SIZE];
  logic [KW:0]               rd_data;
  logic                      issue;
  logic                      hit;
  logic                      mem_we;
  logic [IW-1:0]             mem_waddr;
  logic [KW:0]               mem_wdata;
  logic [1:0]                res_status;
  logic [IW-1:0]             res_idx;
  logic [IW+3:0]             slot_wide;

  // Four restoring steps per cycle for both remainders.
  always_comb begin
    logic [dht_pkg::REM_W-1:0] h_acc;
    logic [dht_pkg::REM_W-1:0] s_acc;
    h_acc = dht_pkg::REM_W'(rem_h);
    s_acc = dht_pkg::REM_W'(rem_s);
    for (int i = 0; i < dht_pkg::HASH_STEPS; i++) begin
      h_acc = dht_pkg::mod_shift(h_acc, kshift[KW-1-i], MOD_T);
      s_acc = dht_pkg::mod_shift(s_acc, kshift[KW-1-i], MOD_S);
    end
    rem_h_next = IW'(h_acc);
    rem_s_next = SW'(s_acc);
  end

  always_comb begin
    idx_sum = (IW + 1)'(rd_idx) + (IW + 1)'(stride);
    if (idx_sum >= (IW + 1)'(TABLE_SIZE)) begin
      idx_sum = idx_sum - (IW + 1)'(TABLE_SIZE);
    end
    rd_idx_next = idx_sum[IW-1:0];
  end

  assign issue = (issued != CW'(TABLE_SIZE));
  assign hit = (op_q == dht_pkg::OP_INSERT) ? !rd_data[KW]
             : (rd_data[KW] && (rd_data[KW-1:0] == key_q));

  assign sts.clr_last    = (clr_addr == IW'(TABLE_SIZE - 1));
  assign sts.hash_last   = (hcnt == dht_pkg::HCNT_W'(dht_pkg::HASH_CYCLES - 1));
  assign sts.stride_last = (scnt == SCW'(SPW - 1));
  assign sts.probe_done  = pend && (hit || (compared == CW'(TABLE_SIZE - 1)));
  assign sts.out_free    = !out_valid || !out_stall;

  assign mem_we    = cmd.clr || (cmd.probe && pend && hit && (op_q == dht_pkg::OP_INSERT));
  assign mem_waddr = cmd.clr ? clr_addr : cmp_idx;
  assign mem_wdata = cmd.clr ? '0 : {1'b1, key_q};

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (cmd.probe && issue) begin
      rd_data <= mem[rd_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clr) begin
      clr_addr <= clr_addr + IW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      key_q  <= key;
      op_q   <= opcode;
      kshift <= key;
      rem_h  <= '0;
      rem_s  <= '0;
      hcnt   <= '0;
    end
    if (cmd.hash) begin
      kshift <= kshift << dht_pkg::HASH_STEPS;
      rem_h  <= rem_h_next;
      rem_s  <= rem_s_next;
      hcnt   <= hcnt + dht_pkg::HCNT_W'(1);
      // The step lies in 1..STEP_PRIME, so it is never zero.
      step_q <= SPW'(STEP_PRIME) - SPW'(rem_s_next);
      stride <= '0;
      scnt   <= '0;
    end
    if (cmd.stride) begin
      stride   <= IW'(dht_pkg::mod_shift(dht_pkg::REM_W'(stride), step_q[SPW-1], MOD_T));
      step_q   <= step_q << 1;
      scnt     <= scnt + SCW'(1);
      rd_idx   <= rem_h;
      issued   <= '0;
      compared <= '0;
      pend     <= 1'b0;
    end
    if (cmd.probe) begin
      // Reads are issued one per cycle; each read is compared in the cycle after it is issued.
      pend <= issue;
      if (issue) begin
        cmp_idx <= rd_idx;
        rd_idx  <= rd_idx_next;
        issued  <= issued + CW'(1);
      end
      if (pend) begin
        compared <= compared + CW'(1);
      end
      if (sts.probe_done) begin
        if (hit) begin
          res_status <= (op_q == dht_pkg::OP_INSERT) ? dht_pkg::ST_INSERTED
                                                     : dht_pkg::ST_FOUND;
          res_idx    <= cmp_idx;
        end else begin
          res_status <= (op_q == dht_pkg::OP_INSERT) ? dht_pkg::ST_FULL
                                                     : dht_pkg::ST_NOT_FOUND;
          res_idx    <= '0;
        end
      end
    end
  end

  assign slot_wide = (IW + 4)'(res_idx);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      status     <= res_status;
      slot_index <= slot_wide[3:0];
    end
  end

endmodule

[design/dht_ctrl.sv]
// Controller state machine sequencing clear, hash, stride, probe and result load.
`timescale 1ns / 1ps

module dht_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  dht_pkg::dht_sts_t sts,
  output dht_pkg::dht_cmd_t cmd
);

  typedef enum logic [5:0] {
    S_CLEAR  = 6'b000001,
    S_IDLE   = 6'b000010,
    S_HASH   = 6'b000100,
    S_STRIDE = 6'b001000,
    S_PROBE  = 6'b010000,
    S_FINISH = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_CLEAR: begin
        cmd.clr = 1'b1;
        if (sts.clr_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_HASH;
        end
      end
      S_HASH: begin
        cmd.hash = 1'b1;
        if (sts.hash_last) begin
          state_next = S_STRIDE;
        end
      end
      S_STRIDE: begin
        cmd.stride = 1'b1;
        if (sts.stride_last) begin
          state_next = S_PROBE;
        end
      end
      S_PROBE: begin
        cmd.probe = 1'b1;
        if (sts.probe_done) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

endmodule

[design/double_hash_table.sv]
// Top level of the double hashing open-addressing hash table.
`timescale 1ns / 1ps

// Each transaction inserts or searches one 32-bit key in a table of TABLE_SIZE
// slots and returns one result: inserted, table full, found or not found, with
// the slot number. After reset the block clears its slot memory, one entry per
// cycle, before it takes its first transaction. One operation then reduces the
// key (four key bits per cycle), reduces the step, probes the table (one memory
// read per cycle through the read port of the slot memory) and loads the result
// register; no new transaction is taken until that operation is done. A new
// transaction is taken while the previous result still waits in the output
// register.
module double_hash_table #(
  parameter int TABLE_SIZE = dht_pkg::DEF_TABLE_SIZE,
  parameter int STEP_PRIME = dht_pkg::DEF_STEP_PRIME
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      opcode,
  input  logic [dht_pkg::KEY_W-1:0] key,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [1:0]                status,
  output logic [3:0]                slot_index
);

  dht_pkg::dht_cmd_t cmd;
  dht_pkg::dht_sts_t sts;

  dht_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  dht_datapath #(
    .TABLE_SIZE (TABLE_SIZE),
    .STEP_PRIME (STEP_PRIME)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .opcode     (opcode),
    .key        (key),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .status     (status),
    .slot_index (slot_index)
  );

endmodule

[design/dht_checker.sv]
// Port-level assertion checker for the double hash table, bound to the top level.
`timescale 1ns / 1ps
`include "double_hash_table_assert.svh"

module dht_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [1:0] status,
  input logic [3:0] slot_index
);

  `DHT_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid, "stalled result dropped")
  `DHT_ASSERT_NEXT(a_out_stable, clk, rst, out_valid && out_stall, $stable(status) && $stable(slot_index), "stalled result changed")
  `DHT_ASSERT_IMP(a_miss_zero, clk, rst, out_valid && (status == dht_pkg::ST_FULL || status == dht_pkg::ST_NOT_FOUND), slot_index == 4'd0, "slot number not zero on full or not found")
  `DHT_ASSERT_NEXT(a_busy_after_accept, clk, rst, in_valid && !in_stall, in_stall, "second transaction taken while busy")

endmodule

bind double_hash_table dht_checker u_dht_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_stall   (in_stall),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .status     (status),
  .slot_index (slot_index)
);

[tb/sv/double_hash_table_tb.sv]
// Self-checking testbench for the double hash table: directed and random inserts and searches.
`timescale 1ns / 1ps

module double_hash_table_tb;

  localparam int unsigned TBL_SIZE  = dht_pkg::DEF_TABLE_SIZE;
  localparam int unsigned STEP_MOD  = dht_pkg::DEF_STEP_PRIME;
  localparam int          RAND_OPS  = 930;
  localparam int          HOLD_AT   = 150;
  localparam int          HOLD_LEN  = 200;
  localparam int          QUIET_LO  = 500;
  localparam int          QUIET_HI  = 600;

  typedef struct {
    logic        op;
    logic [31:0] key;
    int          gap;
  } table_op_t;

  typedef struct {
    logic [1:0] status;
    logic [3:0] slot;
  } table_reply_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        opcode = dht_pkg::OP_INSERT;
  logic [31:0] key = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  status;
  logic [3:0]  slot_index;

  table_op_t    pending_ops[$];
  table_reply_t table_replies[$];
  logic [31:0]  issued_keys[$];

  // Private copy of the slot memory used to predict each reply.
  logic [31:0] model_key[TBL_SIZE];
  logic        model_valid[TBL_SIZE];

  int fails = 0;
  int gap_left = 0;
  int stall_left = 0;
  int hold_left = 0;
  int replies_seen = 0;
  int total_ops = 0;
  bit held = 1'b0;

  double_hash_table DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .opcode    (opcode),
    .key       (key),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .slot_index(slot_index)
  );

  always #5 clk = ~clk;

  // Mostly zero or short, now and then long.
  function automatic int pick_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  // Walks the probe sequence of one transaction and records the reply it must produce.
  function automatic void probe_table(input logic op, input logic [31:0] k);
    int unsigned  home;
    int unsigned  stride;
    int unsigned  idx;
    bit           done;
    table_reply_t r;
    home   = k % TBL_SIZE;
    stride = (STEP_MOD - (k % STEP_MOD)) % TBL_SIZE;
    idx    = home;
    done   = 1'b0;
    r.status = (op == dht_pkg::OP_INSERT) ? dht_pkg::ST_FULL : dht_pkg::ST_NOT_FOUND;
    r.slot   = '0;
    for (int i = 0; i < TBL_SIZE && !done; i++) begin
      if (op == dht_pkg::OP_INSERT) begin
        if (!model_valid[idx]) begin
          model_key[idx]   = k;
          model_valid[idx] = 1'b1;
          r.status = dht_pkg::ST_INSERTED;
          r.slot   = idx[3:0];
          done     = 1'b1;
        end
      end else if (model_valid[idx] && model_key[idx] == k) begin
        r.status = dht_pkg::ST_FOUND;
        r.slot   = idx[3:0];
        done     = 1'b1;
      end
      idx = idx + stride;
      if (idx >= TBL_SIZE) idx = idx - TBL_SIZE;
    end
    table_replies.push_back(r);
  endfunction

  task automatic queue_op(input logic op, input logic [31:0] k, input int gap);
    table_op_t t;
    t.op  = op;
    t.key = k;
    t.gap = gap;
    pending_ops.push_back(t);
    if (op == dht_pkg::OP_INSERT) issued_keys.push_back(k);
  endtask

  // A key that is likely to share its home slot with an earlier one.
  function automatic logic [31:0] pick_key();
    int          r;
    logic [31:0] base;
    r = $urandom_range(0, 99);
    base = (issued_keys.size() != 0) ? issued_keys[$urandom_range(0, issued_keys.size() - 1)]
                                     : $urandom();
    if (r < 45) return base;
    if (r < 70) return base + TBL_SIZE * $urandom_range(1, 50000);
    if (r < 75) return $urandom_range(0, 40);
    if (r < 80) return 32'hFFFF_FFFF - $urandom_range(0, 40);
    return $urandom();
  endfunction

  // Driver: a new transaction is presented only when the current one is accepted or none is up.
  always @(posedge clk) begin
    table_op_t t;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) probe_table(opcode, key);
      if (!in_valid || !in_stall) begin
        if (gap_left != 0) begin
          in_valid <= 1'b0;
          gap_left = gap_left - 1;
        end else if (pending_ops.size() != 0) begin
          t = pending_ops.pop_front();
          in_valid <= 1'b1;
          opcode   <= t.op;
          key      <= t.key;
          gap_left = t.gap;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each accepted result and drives the receiver's stall.
  always @(posedge clk) begin
    table_reply_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (table_replies.size() == 0) begin
          $error("unexpected result: status %0d slot_index %0d", status, slot_index);
          fails++;
        end else begin
          want = table_replies.pop_front();
          if (status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, status);
            fails++;
          end
          if (slot_index !== want.slot) begin
            $error("slot_index: expected %0d, got %0d", want.slot, slot_index);
            fails++;
          end
        end
        replies_seen++;
      end
      // One long hold-off lets the block fill up and push back on its input.
      if (!held && replies_seen >= HOLD_AT) begin
        held = 1'b1;
        hold_left = HOLD_LEN;
      end
      if (hold_left != 0) begin
        out_stall <= 1'b1;
        hold_left = hold_left - 1;
      end else if (replies_seen >= QUIET_LO && replies_seen < QUIET_HI) begin
        out_stall <= 1'b0;
      end else if (stall_left != 0) begin
        out_stall <= 1'b1;
        stall_left = stall_left - 1;
      end else begin
        out_stall <= 1'b0;
        stall_left = pick_len();
      end
    end
  end

  initial begin
    int r;
    for (int i = 0; i < TBL_SIZE; i++) begin
      model_key[i]   = '0;
      model_valid[i] = 1'b0;
    end

    // Directed part: empty table, duplicates, shared home slots and extreme keys.
    queue_op(dht_pkg::OP_SEARCH, 32'h0000_0000, pick_len());
    queue_op(dht_pkg::OP_INSERT, 32'h0000_0000, pick_len());
    queue_op(dht_pkg::OP_INSERT, 32'h0000_0000, pick_len());
    queue_op(dht_pkg::OP_INSERT, 32'h0000_0000, pick_len());
    queue_op(dht_pkg::OP_SEARCH, 32'h0000_0000, pick_len());
    queue_op(dht_pkg::OP_INSERT, 32'hFFFF_FFFF, pick_len());
    queue_op(dht_pkg::OP_SEARCH, 32'hFFFF_FFFF, pick_len());
    queue_op(dht_pkg::OP_INSERT, 32'd13, pick_len());
    queue_op(dht_pkg::OP_SEARCH, 32'd13, pick_len());
    queue_op(dht_pkg::OP_SEARCH, 32'd26, pick_len());
    queue_op(dht_pkg::OP_INSERT, 32'd7, pick_len());
    queue_op(dht_pkg::OP_SEARCH, 32'd7, pick_len());
    queue_op(dht_pkg::OP_SEARCH, 32'h8000_0000, pick_len());
    queue_op(dht_pkg::OP_SEARCH, 32'h7FFF_FFFF, pick_len());
    queue_op(dht_pkg::OP_SEARCH, 32'h5555_AAAA, pick_len());
    queue_op(dht_pkg::OP_SEARCH, 32'hAAAA_5555, pick_len());

    // Random part: rare inserts so the table fills slowly, then full-table traffic.
    for (int i = 0; i < RAND_OPS; i++) begin
      r = $urandom_range(0, 99);
      queue_op((r < 2) ? dht_pkg::OP_INSERT : dht_pkg::OP_SEARCH, pick_key(),
               (i >= 400 && i < 500) ? 0 : pick_len());
    end
    total_ops = pending_ops.size();

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Every transaction sent must come back as exactly one checked result.
    wait (replies_seen == total_ops);
    repeat (40) @(posedge clk);
    if (fails == 0 && replies_seen == total_ops && table_replies.size() == 0)
      $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

  initial begin
    #5ms;
    $display("tb: failure");
    $finish;
  end

endmodule

[filelist.f]
+incdir+design
design/dht_pkg.sv
design/dht_datapath.sv
design/dht_ctrl.sv
design/double_hash_table.sv
design/dht_checker.sv
tb/sv/double_hash_table_tb.sv
